### design/rv32m_pkg.sv
// shared types and constants of the rv32m multiply/divide unit
package rv32m_pkg;

   localparam int unsigned XLEN      = 32;
   localparam int unsigned NUM_CELLS = XLEN;

   localparam logic [2:0] OP_MUL    = 3'd0;
   localparam logic [2:0] OP_MULH   = 3'd1;
   localparam logic [2:0] OP_MULHSU = 3'd2;
   localparam logic [2:0] OP_MULHU  = 3'd3;
   localparam logic [2:0] OP_DIV    = 3'd4;
   localparam logic [2:0] OP_DIVU   = 3'd5;
   localparam logic [2:0] OP_REM    = 3'd6;
   localparam logic [2:0] OP_REMU   = 3'd7;

   typedef struct packed {
      logic              valid;
      logic [2:0]        op;
      logic              neg;
      logic [XLEN-1:0]   dvs;
      logic [2*XLEN-1:0] acc;
   } stage_type;

endpackage

### design/rv32m_cell.sv
// one shift-add / restoring-subtract step of the multiply/divide chain
module rv32m_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  rv32m_pkg::stage_type stage_in,
   output rv32m_pkg::stage_type stage_out
);

   localparam int unsigned W = rv32m_pkg::XLEN;

   rv32m_pkg::stage_type stage_ff, stage_in_w;
   logic [W:0]   mul_sum;
   logic [W:0]   div_t;
   logic [W+1:0] div_diff;
   logic         div_ge;
   logic [W-1:0] rem_next;

   always_comb begin
      mul_sum  = {1'b0, stage_in.acc[2*W-1:W]}
               + (stage_in.acc[0] ? {1'b0, stage_in.dvs} : {(W+1){1'b0}});
      div_t    = {stage_in.acc[2*W-1:W], stage_in.acc[W-1]};
      div_diff = {1'b0, div_t} - {2'b00, stage_in.dvs};
      div_ge   = ~div_diff[W+1];
      rem_next = div_ge ? div_diff[W-1:0] : div_t[W-1:0];
      stage_in_w = stage_in;
      if (stage_in.op[2]) begin
         stage_in_w.acc = {rem_next, stage_in.acc[W-2:0], div_ge};
      end else begin
         stage_in_w.acc = {mul_sum, stage_in.acc[W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in_w.valid;
      end
      if (advance) begin
         stage_ff.op  <= stage_in_w.op;
         stage_ff.neg <= stage_in_w.neg;
         stage_ff.dvs <= stage_in_w.dvs;
         stage_ff.acc <= stage_in_w.acc;
      end
   end

   assign stage_out = stage_ff;

endmodule

### design/rv32m_multiply_divide_unit.sv
// top level of the rv32m multiply/divide execute unit
//
//   channel  direction  ports
//   req      in         req_valid req_ready req_op req_first_operand req_second_operand
//   rsp      out        rsp_valid rsp_ready rsp_result_value
//
// one beat enters per cycle while the output is not stalled; each beat walks a chain
// of 32 cells, one operand bit per cell; the first cell loads at the accepting edge,
// then the beat passes the remaining 31 cells and the sign fix-up/output register
// reset clears the valid bits of the cells and the output register
// a stalled output register freezes the whole chain; req_ready follows it
module rv32m_multiply_divide_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [31:0] req_first_operand,
   input  logic [31:0] req_second_operand,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result_value
);

   localparam int unsigned W = rv32m_pkg::XLEN;
   localparam int unsigned N = rv32m_pkg::NUM_CELLS;

   rv32m_pkg::stage_type chain [0:N];
   logic         advance;
   logic         sign_a, sign_b, is_div, b_zero;
   logic [W-1:0] mag_a, mag_b;
   logic [2*W-1:0] prod_fix;
   logic [W-1:0] quo_fix, rem_fix;
   logic [W-1:0] result_in;
   logic         rsp_valid_ff;
   logic [W-1:0] rsp_result_ff;

   // the chain moves whenever the output register can take a beat
   assign advance   = ~rsp_valid_ff | rsp_ready;
   assign req_ready = advance;

   // operand signs only count for the signed flavors
   always_comb begin
      is_div = req_op[2];
      sign_a = req_first_operand[W-1] & ((req_op == rv32m_pkg::OP_MULH)
               || (req_op == rv32m_pkg::OP_MULHSU) || (req_op == rv32m_pkg::OP_DIV)
               || (req_op == rv32m_pkg::OP_REM));
      sign_b = req_second_operand[W-1] & ((req_op == rv32m_pkg::OP_MULH)
               || (req_op == rv32m_pkg::OP_DIV) || (req_op == rv32m_pkg::OP_REM));
      b_zero = (req_second_operand == {W{1'b0}});
      mag_a  = sign_a ? (~req_first_operand + 1'b1) : req_first_operand;
      mag_b  = sign_b ? (~req_second_operand + 1'b1) : req_second_operand;
      chain[0].valid = req_valid;
      chain[0].op    = req_op;
      chain[0].dvs   = mag_b;
      chain[0].acc   = {{W{1'b0}}, mag_a};
      // remainder keeps the dividend sign; a quotient by zero stays all ones
      if (!is_div) begin
         chain[0].neg = sign_a ^ sign_b;
      end else if (req_op == rv32m_pkg::OP_REM) begin
         chain[0].neg = sign_a;
      end else begin
         chain[0].neg = (sign_a ^ sign_b) & ~b_zero;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_cell
      rv32m_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_in  (chain[i]),
         .stage_out (chain[i+1])
      );
   end

   // sign fix-up and result select
   always_comb begin
      prod_fix = chain[N].neg ? (~chain[N].acc + 1'b1) : chain[N].acc;
      quo_fix  = chain[N].neg ? (~chain[N].acc[W-1:0] + 1'b1) : chain[N].acc[W-1:0];
      rem_fix  = chain[N].neg ? (~chain[N].acc[2*W-1:W] + 1'b1) : chain[N].acc[2*W-1:W];
      case (chain[N].op)
         rv32m_pkg::OP_MUL:    result_in = chain[N].acc[W-1:0];
         rv32m_pkg::OP_MULH,
         rv32m_pkg::OP_MULHSU,
         rv32m_pkg::OP_MULHU:  result_in = prod_fix[2*W-1:W];
         rv32m_pkg::OP_DIV,
         rv32m_pkg::OP_DIVU:   result_in = quo_fix;
         default:              result_in = rem_fix;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= chain[N].valid;
      end
      if (advance) begin
         rsp_result_ff <= result_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_result_ff;

endmodule

### tb/testbench.sv
// self-checking testbench for the rv32m multiply/divide execute unit
`timescale 1ns / 100ps

module testbench;

   localparam int NUM_RANDOM   = 1900;
   localparam int LATENCY      = 40;
   localparam int LONG_HOLD    = 150;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_op = rv32m_pkg::OP_MUL;
   logic [31:0] req_first_operand = '0;
   logic [31:0] req_second_operand = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_result_value;

   // directed row: expected value typed in when obvious, else taken from the predictor
   typedef struct {
      logic [2:0]  op;
      logic [31:0] a;
      logic [31:0] b;
      bit          fixed;
      logic [31:0] value;
   } row_type;

   logic [31:0] expected_values[$];
   int          mismatch_count = 0;
   int          result_count   = 0;
   int          beats_sent     = 0;
   bit          quiet_tail     = 1'b0;
   bit          hold_request   = 1'b0;
   int          op_seen[8];

   always #6 clock = ~clock;

   rv32m_multiply_divide_unit uut (.*);

   function automatic logic [31:0] abs32(logic [31:0] v);
      return v[31] ? 32'(-v) : v;
   endfunction

   // predicted result of one operation, written from the rv32m rules
   function automatic logic [31:0] rv32m_result(logic [2:0] op, logic [31:0] a,
                                                logic [31:0] b);
      logic [63:0] prod;
      logic [31:0] q;
      case (op)
         rv32m_pkg::OP_MUL: begin
            prod = a * b;
            return prod[31:0];
         end
         rv32m_pkg::OP_MULH: begin
            prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
            return prod[63:32];
         end
         rv32m_pkg::OP_MULHSU: begin
            prod = {{32{a[31]}}, a} * {32'd0, b};
            return prod[63:32];
         end
         rv32m_pkg::OP_MULHU: begin
            prod = {32'd0, a} * {32'd0, b};
            return prod[63:32];
         end
         rv32m_pkg::OP_DIV: begin
            if (b == 0) return 32'hffffffff;
            if (a == 32'h80000000 && b == 32'hffffffff) return 32'h80000000;
            q = abs32(a) / abs32(b);
            return (a[31] ^ b[31]) ? 32'(-q) : q;
         end
         rv32m_pkg::OP_DIVU: return (b == 0) ? 32'hffffffff : a / b;
         rv32m_pkg::OP_REM: begin
            if (b == 0) return a;
            if (a == 32'h80000000 && b == 32'hffffffff) return 32'd0;
            q = abs32(a) % abs32(b);
            return a[31] ? 32'(-q) : q;
         end
         default:   return (b == 0) ? a : a % b;
      endcase
   endfunction

   // random operand with a bias toward corner patterns
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return 32'hffffffff;
         2: return 32'h80000000;
         3: return 32'h7fffffff;
         4: return 32'($urandom_range(0, 15));
         5: return 32'(-$urandom_range(1, 15));
         default: return $urandom;
      endcase
   endfunction

   // offer one beat and wait for its acceptance
   task automatic send_beat(logic [2:0] op, logic [31:0] a, logic [31:0] b,
                            bit fixed, logic [31:0] value, bit gaps);
      int gap;
      if (gaps && !quiet_tail && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_op             <= op;
      req_first_operand  <= a;
      req_second_operand <= b;
      do @(posedge clock); while (!req_ready);
      // beat accepted at this edge
      expected_values.push_back(fixed ? value : rv32m_result(op, a, b));
      op_seen[op]++;
      beats_sent++;
   endtask

   // receiver: random stall bursts, one long hold on request, none at the tail
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
            rsp_ready <= 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(1, 19);
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         result_count++;
         if (expected_values.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result beat: actual %h", rsp_result_value);
         end else begin
            logic [31:0] want;
            want = expected_values.pop_front();
            if (rsp_result_value !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result mismatch: expected %h actual %h", want, rsp_result_value);
            end
         end
      end
   end

   // stimulus
   initial begin
      row_type rows[$];
      int   k;
      logic [2:0] op;
      rows = '{
         '{rv32m_pkg::OP_MUL,    32'd0,        32'd0,        1, 32'd0},
         '{rv32m_pkg::OP_MUL,    32'hffffffff, 32'hffffffff, 1, 32'd1},
         '{rv32m_pkg::OP_MULH,   32'hffffffff, 32'hffffffff, 1, 32'd0},
         '{rv32m_pkg::OP_MULH,   32'h80000000, 32'h80000000, 1, 32'h40000000},
         '{rv32m_pkg::OP_MULHSU, 32'hffffffff, 32'hffffffff, 1, 32'hffffffff},
         '{rv32m_pkg::OP_MULHSU, 32'h80000000, 32'h7fffffff, 0, 32'd0},
         '{rv32m_pkg::OP_MULHU,  32'hffffffff, 32'hffffffff, 1, 32'hfffffffe},
         '{rv32m_pkg::OP_MULHU,  32'h12345678, 32'h9abcdef0, 0, 32'd0},
         '{rv32m_pkg::OP_DIV,    32'd1234,     32'd0,        1, 32'hffffffff},
         '{rv32m_pkg::OP_DIV,    32'h80000000, 32'hffffffff, 1, 32'h80000000},
         '{rv32m_pkg::OP_DIV,    32'hfffffff9, 32'd2,        1, 32'hfffffffd},
         '{rv32m_pkg::OP_DIV,    32'h7fffffff, 32'h80000000, 1, 32'd0},
         '{rv32m_pkg::OP_DIVU,   32'hffffffff, 32'd0,        1, 32'hffffffff},
         '{rv32m_pkg::OP_DIVU,   32'hffffffff, 32'd1,        1, 32'hffffffff},
         '{rv32m_pkg::OP_DIVU,   32'h80000000, 32'hffffffff, 1, 32'd0},
         '{rv32m_pkg::OP_REM,    32'hdeadbeef, 32'd0,        1, 32'hdeadbeef},
         '{rv32m_pkg::OP_REM,    32'h80000000, 32'hffffffff, 1, 32'd0},
         '{rv32m_pkg::OP_REM,    32'hfffffff9, 32'd2,        1, 32'hffffffff},
         '{rv32m_pkg::OP_REM,    32'd7,        32'hfffffffe, 1, 32'd1},
         '{rv32m_pkg::OP_REMU,   32'h80000000, 32'd0,        1, 32'h80000000},
         '{rv32m_pkg::OP_REMU,   32'hffffffff, 32'd10,       1, 32'd5},
         '{rv32m_pkg::OP_REMU,   32'h55555555, 32'haaaaaaaa, 0, 32'd0}
      };
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i])
         send_beat(rows[i].op, rows[i].a, rows[i].b, rows[i].fixed, rows[i].value, 1);
      req_valid <= 1'b0;

      // sender pause until the pipeline drains
      while (expected_values.size() != 0) @(posedge clock);

      for (k = 0; k < NUM_RANDOM; k++) begin
         // long receiver hold while beats keep coming, so the chain fills up
         if (k == 300) hold_request = 1'b1;
         if (k == NUM_RANDOM - 200) quiet_tail = 1'b1;
         op = 3'($urandom_range(0, 7));
         send_beat(op, pick_operand(), pick_operand(), 0, 32'd0, 1);
      end
      req_valid <= 1'b0;

      while (expected_values.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);

      $display("sent %0d beats, %0d results checked, %0d mismatches", beats_sent,
               result_count, mismatch_count);
      $display("op mix: mul %0d mulh %0d mulhsu %0d mulhu %0d div %0d divu %0d rem %0d remu %0d",
               op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4], op_seen[5],
               op_seen[6], op_seen[7]);
      if (mismatch_count == 0 && expected_values.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // watchdog
   initial begin
      #(12 * 400000);
      $display("watchdog expired with %0d results outstanding", expected_values.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule
